### hw/rtl/segi_pkg.sv
// Shared types and widths for the 2D segment intersection unit.
// No dependencies; every other file imports this package.
package segi_pkg;

  // Coordinate width, signed fixed point.
  localparam int CoordBits = 32;
  // Coordinate differences.
  localparam int DiffW = CoordBits + 1;
  // One product of two differences.
  localparam int ProdW = 2 * DiffW;
  // Cross or dot products (sum of two products).
  localparam int CrossW = ProdW + 1;
  // Magnitude of the denominator and the t numerator.
  localparam int MagW = CrossW - 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;
  typedef logic signed [ProdW-1:0]     prod_t;
  typedef logic signed [CrossW-1:0]    cross_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;
  } seg_in_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_x;
    coord_t hit_y;
  } seg_out_t;

  // Item handed from the geometry front end to the divider.
  typedef struct packed {
    logic              hit;
    coord_t            base_x;
    coord_t            base_y;
    logic              neg_x;
    logic              neg_y;
    logic [DiffW-1:0]  mag_x;
    logic [DiffW-1:0]  mag_y;
    logic [MagW-1:0]   tn;
    logic [MagW-1:0]   den;
  } div_item_t;

  // Item handed from the divider to the output stage.
  typedef struct packed {
    logic              hit;
    coord_t            base_x;
    coord_t            base_y;
    logic              neg_x;
    logic              neg_y;
    logic [DiffW-1:0]  q_x;
    logic [DiffW-1:0]  q_y;
  } div_res_t;

endpackage

### hw/rtl/segi_front.sv
// Geometry front end: differences, products, cross products, hit classification.
// Four register stages. Depends on segi_pkg.
module segi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  segi_pkg::seg_in_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output segi_pkg::div_item_t out_item_o
);
  import segi_pkg::*;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t c_x;
    coord_t c_y;
    diff_t  rx;
    diff_t  ry;
    diff_t  sx;
    diff_t  sy;
    diff_t  wx;
    diff_t  wy;
  } s1_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t c_x;
    coord_t c_y;
    diff_t  rx;
    diff_t  ry;
    prod_t  rs1;
    prod_t  rs2;
    prod_t  ws1;
    prod_t  ws2;
    prod_t  wr1;
    prod_t  wr2;
    prod_t  d1;
    prod_t  d2;
    prod_t  l1;
    prod_t  l2;
  } s2_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t c_x;
    coord_t c_y;
    diff_t  rx;
    diff_t  ry;
    cross_t den;
    cross_t tn;
    cross_t un;
    cross_t dot;
    cross_t len2;
  } s3_t;

  localparam cross_t CrossZero = '0;

  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  s3_t       s3_d, s3_q;
  div_item_t s4_d, s4_q;
  logic      v1_q, v2_q, v3_q, v4_q;
  logic      en1, en2, en3, en4;

  logic              par, den_neg, par_hit, np_hit;
  cross_t            tn_abs, den_abs;
  logic [DiffW-1:0]  rx_abs, ry_abs;

  // A stage loads when it is empty or its content moves on.
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // Stage 1: edge vectors.
  always_comb begin
    s1_d.a_x = in_item_i.a_x;
    s1_d.a_y = in_item_i.a_y;
    s1_d.c_x = in_item_i.c_x;
    s1_d.c_y = in_item_i.c_y;
    s1_d.rx  = diff_t'(in_item_i.b_x) - diff_t'(in_item_i.a_x);
    s1_d.ry  = diff_t'(in_item_i.b_y) - diff_t'(in_item_i.a_y);
    s1_d.sx  = diff_t'(in_item_i.d_x) - diff_t'(in_item_i.c_x);
    s1_d.sy  = diff_t'(in_item_i.d_y) - diff_t'(in_item_i.c_y);
    s1_d.wx  = diff_t'(in_item_i.c_x) - diff_t'(in_item_i.a_x);
    s1_d.wy  = diff_t'(in_item_i.c_y) - diff_t'(in_item_i.a_y);
  end

  // Stage 2: all partial products.
  always_comb begin
    s2_d.a_x = s1_q.a_x;
    s2_d.a_y = s1_q.a_y;
    s2_d.c_x = s1_q.c_x;
    s2_d.c_y = s1_q.c_y;
    s2_d.rx  = s1_q.rx;
    s2_d.ry  = s1_q.ry;
    s2_d.rs1 = s1_q.rx * s1_q.sy;
    s2_d.rs2 = s1_q.ry * s1_q.sx;
    s2_d.ws1 = s1_q.wx * s1_q.sy;
    s2_d.ws2 = s1_q.wy * s1_q.sx;
    s2_d.wr1 = s1_q.wx * s1_q.ry;
    s2_d.wr2 = s1_q.wy * s1_q.rx;
    s2_d.d1  = s1_q.wx * s1_q.rx;
    s2_d.d2  = s1_q.wy * s1_q.ry;
    s2_d.l1  = s1_q.rx * s1_q.rx;
    s2_d.l2  = s1_q.ry * s1_q.ry;
  end

  // Stage 3: cross and dot products.
  always_comb begin
    s3_d.a_x  = s2_q.a_x;
    s3_d.a_y  = s2_q.a_y;
    s3_d.c_x  = s2_q.c_x;
    s3_d.c_y  = s2_q.c_y;
    s3_d.rx   = s2_q.rx;
    s3_d.ry   = s2_q.ry;
    s3_d.den  = cross_t'(s2_q.rs1) - cross_t'(s2_q.rs2);
    s3_d.tn   = cross_t'(s2_q.ws1) - cross_t'(s2_q.ws2);
    s3_d.un   = cross_t'(s2_q.wr1) - cross_t'(s2_q.wr2);
    s3_d.dot  = cross_t'(s2_q.d1) + cross_t'(s2_q.d2);
    s3_d.len2 = cross_t'(s2_q.l1) + cross_t'(s2_q.l2);
  end

  // Stage 4: classify and set up the division.
  always_comb begin
    par     = (s3_q.den == CrossZero);
    den_neg = s3_q.den[CrossW-1];
    par_hit = par && (s3_q.len2 != CrossZero) && (s3_q.un == CrossZero) &&
              (s3_q.dot >= CrossZero) && (s3_q.dot <= s3_q.len2);
    if (den_neg) begin
      np_hit = (s3_q.tn <= CrossZero) && (s3_q.tn >= s3_q.den) &&
               (s3_q.un <= CrossZero) && (s3_q.un > s3_q.den);
    end else begin
      np_hit = !par && (s3_q.tn >= CrossZero) && (s3_q.tn <= s3_q.den) &&
               (s3_q.un >= CrossZero) && (s3_q.un < s3_q.den);
    end
    tn_abs  = den_neg ? -s3_q.tn : s3_q.tn;
    den_abs = den_neg ? -s3_q.den : s3_q.den;
    rx_abs  = s3_q.rx[DiffW-1] ? -s3_q.rx : s3_q.rx;
    ry_abs  = s3_q.ry[DiffW-1] ? -s3_q.ry : s3_q.ry;

    // No hit: zero point, empty division.
    s4_d        = '0;
    s4_d.den    = MagW'(1);
    if (np_hit) begin
      s4_d.hit    = 1'b1;
      s4_d.base_x = s3_q.a_x;
      s4_d.base_y = s3_q.a_y;
      s4_d.neg_x  = s3_q.rx[DiffW-1];
      s4_d.neg_y  = s3_q.ry[DiffW-1];
      s4_d.mag_x  = rx_abs;
      s4_d.mag_y  = ry_abs;
      s4_d.tn     = tn_abs[MagW-1:0];
      s4_d.den    = den_abs[MagW-1:0];
    end else if (par_hit) begin
      // Collinear overlap: report C, quotient stays zero.
      s4_d.hit    = 1'b1;
      s4_d.base_x = s3_q.c_x;
      s4_d.base_y = s3_q.c_y;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) s3_q <= s3_d;
    if (en4 && v3_q) s4_q <= s4_d;
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = s4_q;

`ifndef SYNTH
  // A missed item carries nothing into the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !s4_q.hit) |-> (s4_q.tn == '0 && s4_q.base_x == '0 && s4_q.base_y == '0))
    else $error("front: non-hit item with nonzero setup");
`endif

endmodule

### hw/rtl/segi_div.sv
// Pipelined scaled divider: q = floor(tn * mag / den), one bit of mag per stage.
// Two lanes (x and y) share the stage control. Depends on segi_pkg.
module segi_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  segi_pkg::div_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output segi_pkg::div_res_t  out_item_o
);
  import segi_pkg::*;

  localparam int Stages = DiffW;

  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [DiffW-1:0] q;
  } lane_t;

  typedef struct packed {
    div_item_t it;
    lane_t     lx;
    lane_t     ly;
  } dst_t;

  // Consume one multiplier bit: rem stays below den, digit is 0, 1 or 2.
  function automatic lane_t div_step(lane_t cur, logic b, logic [MagW-1:0] tn,
                                     logic [MagW-1:0] den);
    logic [MagW+1:0] x;
    logic [MagW+1:0] d1;
    logic [MagW+1:0] d2;
    lane_t           nxt;
    x  = {1'b0, cur.rem, 1'b0} + (b ? {2'b00, tn} : '0);
    d1 = {2'b00, den};
    d2 = {1'b0, den, 1'b0};
    nxt.q = {cur.q[DiffW-2:0], 1'b0};
    if (x >= d2) begin
      x     = x - d2;
      nxt.q = nxt.q + DiffW'(2);
    end else if (x >= d1) begin
      x     = x - d1;
      nxt.q = nxt.q + DiffW'(1);
    end
    nxt.rem = x[MagW-1:0];
    return nxt;
  endfunction

  dst_t              st_q  [Stages];
  dst_t              src_a [Stages];
  dst_t              nxt_a [Stages];
  logic [Stages-1:0] v_q;
  logic [Stages-1:0] vin;
  logic [Stages:0]   en;

  // Ready chain, last stage first.
  always_comb begin
    en[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign in_ready_o = en[0];
  assign vin = {v_q[Stages-2:0], in_valid_i};

  // Stage inputs and one division step per stage.
  always_comb begin
    src_a[0]    = '0;
    src_a[0].it = in_item_i;
    for (int k = 1; k < Stages; k++) begin
      src_a[k] = st_q[k-1];
    end
    for (int k = 0; k < Stages; k++) begin
      nxt_a[k]    = src_a[k];
      nxt_a[k].lx = div_step(src_a[k].lx, src_a[k].it.mag_x[Stages-1-k],
                             src_a[k].it.tn, src_a[k].it.den);
      nxt_a[k].ly = div_step(src_a[k].ly, src_a[k].it.mag_y[Stages-1-k],
                             src_a[k].it.tn, src_a[k].it.den);
    end
  end

  // Valid bits advance with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (en[k] && vin[k]) st_q[k] <= nxt_a[k];
    end
  end

  assign out_valid_o       = v_q[Stages-1];
  assign out_item_o.hit    = st_q[Stages-1].it.hit;
  assign out_item_o.base_x = st_q[Stages-1].it.base_x;
  assign out_item_o.base_y = st_q[Stages-1].it.base_y;
  assign out_item_o.neg_x  = st_q[Stages-1].it.neg_x;
  assign out_item_o.neg_y  = st_q[Stages-1].it.neg_y;
  assign out_item_o.q_x    = st_q[Stages-1].lx.q;
  assign out_item_o.q_y    = st_q[Stages-1].ly.q;

`ifndef SYNTH
  // Remainders stay below the divisor through the whole chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-1] |-> (st_q[Stages-1].lx.rem < st_q[Stages-1].it.den &&
                       st_q[Stages-1].ly.rem < st_q[Stages-1].it.den))
    else $error("div: remainder not below divisor");
`endif

endmodule

### hw/rtl/segment_intersection_2d_unit.sv
// Top level of the 2D segment intersection unit: front end, divider, output register.
// Depends on segi_pkg, segi_front and segi_div.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o   | in_item_i  (seg_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_item_o (seg_out_t)
//
// One item per cycle while the output is not stalled. The divider resolves one
// quotient bit per stage.
// Reset clears only valid bits; the data registers keep their contents.
// A stalled output stops only the stages behind full ones; empty stages fill.
module segment_intersection_2d_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  segi_pkg::seg_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output segi_pkg::seg_out_t out_item_o
);
  import segi_pkg::*;

  logic      fr_valid, fr_ready;
  div_item_t fr_item;
  logic      dv_valid, dv_ready;
  div_res_t  dv_item;

  logic                    out_v_q;
  seg_out_t                out_q, out_d;
  logic signed [DiffW:0]   sum_x, sum_y;

  segi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  segi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_item_o  (dv_item)
  );

  assign dv_ready = !out_v_q || out_ready_i;

  // Apply the signed quotient to the base point.
  always_comb begin
    sum_x = dv_item.neg_x ?
            (DiffW+1)'(dv_item.base_x) - $signed({1'b0, dv_item.q_x}) :
            (DiffW+1)'(dv_item.base_x) + $signed({1'b0, dv_item.q_x});
    sum_y = dv_item.neg_y ?
            (DiffW+1)'(dv_item.base_y) - $signed({1'b0, dv_item.q_y}) :
            (DiffW+1)'(dv_item.base_y) + $signed({1'b0, dv_item.q_y});
    out_d.hit   = dv_item.hit;
    out_d.hit_x = sum_x[CoordBits-1:0];
    out_d.hit_y = sum_y[CoordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dv_ready) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready && dv_valid) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // A miss reports the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.hit || (out_q.hit_x == '0 && out_q.hit_y == '0)))
    else $error("top: miss with nonzero point");

  // Input backpressure only comes from a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_v_q)
    else $error("top: input stalled with empty output");

  // The output register is released only when the sink takes the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("top: held result changed");
`endif

endmodule

### tb/sv/segment_intersection_2d_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 2D segment intersection unit: watches both channels,
// predicts each result from the accepted segment pair and compares. Uses segi_pkg.
module segment_intersection_2d_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  segi_pkg::seg_in_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  segi_pkg::seg_out_t out_item_i,
  output int                 pending_o,
  output int                 errors_o
);
  import segi_pkg::*;

  typedef logic signed [127:0] big_t;

  seg_out_t expected_hits[$];

  // Compute the meeting point of AB and CD with exact wide integers
  function automatic seg_out_t intersect_segments(seg_in_t s);
    big_t ax, ay, bx, by, cx, cy, dx, dy;
    big_t rx, ry, sx, sy, wx, wy, den, tn, un, dot, len2;
    seg_out_t res;
    ax = s.a_x; ay = s.a_y; bx = s.b_x; by = s.b_y;
    cx = s.c_x; cy = s.c_y; dx = s.d_x; dy = s.d_y;
    rx = bx - ax; ry = by - ay;
    sx = dx - cx; sy = dy - cy;
    wx = cx - ax; wy = cy - ay;
    den = rx * sy - ry * sx;
    tn  = wx * sy - wy * sx;
    un  = wx * ry - wy * rx;
    res = '0;
    if (den == 0) begin
      // Parallel: hit at C when C lies on AB
      dot  = wx * rx + wy * ry;
      len2 = rx * rx + ry * ry;
      if (len2 != 0 && un == 0 && dot >= 0 && dot <= len2) begin
        res.hit   = 1'b1;
        res.hit_x = s.c_x;
        res.hit_y = s.c_y;
      end
    end else begin
      // Normalize so that den is positive
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un < den) begin
        res.hit   = 1'b1;
        res.hit_x = coord_t'(ax + (tn * rx) / den);
        res.hit_y = coord_t'(ay + (tn * ry) / den);
      end
    end
    return res;
  endfunction

  assign pending_o = expected_hits.size();

  // Record on input accept, compare on output accept
  always @(posedge clk_i or negedge rst_ni) begin
    seg_out_t want;
    if (!rst_ni) begin
      expected_hits.delete();
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_hits.push_back(intersect_segments(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          $error("result item with nothing expected");
          errors_o <= errors_o + 1;
        end else begin
          want = expected_hits.pop_front();
          if (want !== out_item_i) begin
            if (want.hit !== out_item_i.hit)
              $error("hit: expected %0d, actual %0d", want.hit, out_item_i.hit);
            if (want.hit_x !== out_item_i.hit_x)
              $error("hit_x: expected %0d, actual %0d", want.hit_x, out_item_i.hit_x);
            if (want.hit_y !== out_item_i.hit_y)
              $error("hit_y: expected %0d, actual %0d", want.hit_y, out_item_i.hit_y);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/segment_intersection_2d_unit_tb.sv
`timescale 1ns / 100ps
// Top of the segment intersection testbench: clock, reset, stimulus and verdict.
// Depends on segi_pkg, segment_intersection_2d_unit and segment_intersection_2d_checker.
module segment_intersection_2d_unit_tb;
  import segi_pkg::*;

  localparam int NumRandom = 1850;
  localparam int StallLimit = 5000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  seg_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  seg_out_t out_item;
  int       pending, errors;
  int       send_idle_pct = 26;
  int       recv_idle_pct = 48;
  int       quiet_cycles = 0;

  always #1 clk = ~clk;

  segment_intersection_2d_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item)
  );

  segment_intersection_2d_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .pending_o(pending), .errors_o(errors)
  );

  // Toggle receiver readiness at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle for random cycles, one draw per cycle, then hold the item until accepted
  task automatic send_pair(seg_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic seg_in_t make_pair(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                        coord_t cx, coord_t cy, coord_t dx, coord_t dy);
    seg_in_t s;
    s.a_x = ax; s.a_y = ay; s.b_x = bx; s.b_y = by;
    s.c_x = cx; s.c_y = cy; s.d_x = dx; s.d_y = dy;
    return s;
  endfunction

  // Build a random pair: mostly crossing-prone or collinear, some raw noise
  function automatic seg_in_t random_pair();
    seg_in_t s;
    int      kind, span;
    coord_t  ox, oy;
    kind = $urandom_range(9);
    span = 1 << $urandom_range(2, 30);
    ox = $urandom; oy = $urandom;
    if ($urandom_range(1)) begin
      ox = ox >>> 2; oy = oy >>> 2;
    end
    s.a_x = ox + $urandom_range(span) - span / 2;
    s.a_y = oy + $urandom_range(span) - span / 2;
    s.b_x = ox + $urandom_range(span) - span / 2;
    s.b_y = oy + $urandom_range(span) - span / 2;
    s.c_x = ox + $urandom_range(span) - span / 2;
    s.c_y = oy + $urandom_range(span) - span / 2;
    s.d_x = ox + $urandom_range(span) - span / 2;
    s.d_y = oy + $urandom_range(span) - span / 2;
    case (kind)
      0, 1: begin
        s = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
      end
      2: begin
        // C on the line of AB at a quarter step
        s.c_x = s.a_x + ((s.b_x - s.a_x) >>> 2) * $signed($urandom_range(0, 5));
        s.c_y = s.a_y + ((s.b_y - s.a_y) >>> 2) * $signed($urandom_range(0, 5));
        s.b_x = s.a_x + (((s.b_x - s.a_x) >>> 2) <<< 2);
        s.b_y = s.a_y + (((s.b_y - s.a_y) >>> 2) <<< 2);
        s.c_x = s.a_x + ((s.b_x - s.a_x) >>> 2) * $signed($urandom_range(0, 5));
        s.c_y = s.a_y + ((s.b_y - s.a_y) >>> 2) * $signed($urandom_range(0, 5));
        if ($urandom_range(1)) begin
          s.d_x = s.c_x + (s.b_x - s.a_x);
          s.d_y = s.c_y + (s.b_y - s.a_y);
        end else begin
          s.d_x = s.c_x; s.d_y = s.c_y;
        end
      end
      3: begin
        // Shared endpoints
        if ($urandom_range(1)) begin
          s.c_x = s.b_x; s.c_y = s.b_y;
        end else begin
          s.d_x = s.a_x; s.d_y = s.a_y;
        end
      end
      4: begin
        s.b_x = s.a_x; s.b_y = s.a_y;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Stimulus and verdict
  initial begin
    seg_in_t directed[$];
    coord_t  mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
    directed.push_back(make_pair(mx, mn, mn, mx, mn, mn, mx, mx));
    directed.push_back(make_pair(mn, mn, mn, mn, mn, mn, mn, mn));
    directed.push_back(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
    directed.push_back(make_pair(0, 0, 0, 0, -5, 0, 5, 0));
    directed.push_back(make_pair(0, 0, 100, 0, 40, 0, 40, 0));
    directed.push_back(make_pair(0, 0, 100, 0, 140, 0, 140, 0));
    directed.push_back(make_pair(0, 0, 100, 0, 50, -10, 50, 10));
    directed.push_back(make_pair(0, 0, 100, 0, 50, 10, 50, -10));
    directed.push_back(make_pair(0, 0, 100, 0, 50, -10, 50, 0));
    directed.push_back(make_pair(0, 0, 100, 0, 50, 0, 50, 10));
    directed.push_back(make_pair(0, 0, 100, 0, 0, -10, 0, 10));
    directed.push_back(make_pair(0, 0, 100, 0, 100, -10, 100, 10));
    directed.push_back(make_pair(0, 0, 100, 0, 101, -10, 101, 10));
    directed.push_back(make_pair(0, 0, 100, 0, 0, 0, 100, 0));
    directed.push_back(make_pair(0, 0, 100, 0, 100, 0, 200, 0));
    directed.push_back(make_pair(0, 0, 100, 0, -1, 0, -50, 0));
    directed.push_back(make_pair(0, 0, 100, 0, 0, 5, 100, 5));
    directed.push_back(make_pair(0, 0, 7, 3, 0, 3, 7, -1));
    directed.push_back(make_pair(-7, -3, 0, 0, -7, 0, 0, -3));
    directed.push_back(make_pair(mn, 0, mx, 0, 0, mn, 0, mx));
    directed.push_back(make_pair(0, mx, 0, mn, mx, 1, mn, -1));
    foreach (directed[i]) send_pair(directed[i]);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 26;
      end
      if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Drain the pipeline once before resuming
      if (n == NumRandom / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_pair(random_pair());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
